FILE: rtl/tbf_pkg.sv
// Package for the tiled 4bpp blit and fill engine.
// Shared types, constants and address helper; no dependencies.
package tbf_pkg;
    localparam int MEM_BYTES = 32768;
    localparam int AW = $clog2(MEM_BYTES);
    localparam int CW = 10;

    localparam logic [1:0] MODE_WR   = 2'd0;
    localparam logic [1:0] MODE_RD   = 2'd1;
    localparam logic [1:0] MODE_COPY = 2'd2;
    localparam logic [1:0] MODE_FILL = 2'd3;

    localparam logic [2:0] REG_SRC_BASE   = 3'd0;
    localparam logic [2:0] REG_SRC_WIDTH  = 3'd1;
    localparam logic [2:0] REG_DST_BASE   = 3'd2;
    localparam logic [2:0] REG_DST_WIDTH  = 3'd3;
    localparam logic [2:0] REG_DST_HEIGHT = 3'd4;

    localparam logic [7:0] KEY_OFF = 8'hFF;

    typedef struct packed {
        logic [1:0]    mode;
        logic [AW-1:0] addr;
        logic [7:0]    wdata;
        logic [CW-1:0] sx;
        logic [CW-1:0] sy;
        logic [CW-1:0] dx;
        logic [CW-1:0] dy;
        logic [CW-1:0] cols;
        logic [CW-1:0] rows;
        logic [7:0]    key;
        logic [3:0]    fill;
    } cmd_t;

    function automatic logic [CW-1:0] clip(input logic [CW-1:0] len,
                                           input logic [CW-1:0] start,
                                           input logic [CW-1:0] limit);
        logic [CW-1:0] avail;
        avail = limit - start;
        if (start >= limit) return '0;
        return (len < avail) ? len : avail;
    endfunction

    // stride in tiles, times 32 bytes per tile row
    function automatic logic [CW-1:0] stride(input logic [CW-1:0] w);
        logic [CW:0] s;
        s = ({1'b0, w} + {8'd0, w[2:0]}) >> 3;
        return s[CW-1:0];
    endfunction
endpackage

FILE: rtl/tbf_front.sv
// Front end: accepts commands, clips rectangles, pushes them to a queue.
// Depends on tbf_pkg.
module tbf_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_mode,
    input  logic [tbf_pkg::AW-1:0]   s_mem_addr,
    input  logic [7:0]               s_mem_wdata,
    input  logic [tbf_pkg::CW-1:0]   s_src_x,
    input  logic [tbf_pkg::CW-1:0]   s_src_y,
    input  logic [tbf_pkg::CW-1:0]   s_dst_x,
    input  logic [tbf_pkg::CW-1:0]   s_dst_y,
    input  logic [tbf_pkg::CW-1:0]   s_rect_width,
    input  logic [tbf_pkg::CW-1:0]   s_rect_height,
    input  logic [7:0]               s_color_key,
    input  logic [7:0]               s_fill_value,
    input  logic [tbf_pkg::CW-1:0]   dst_width,
    input  logic [tbf_pkg::CW-1:0]   dst_height,
    output logic                     q_valid,
    input  logic                     q_ready,
    output tbf_pkg::cmd_t            q_cmd
);
    tbf_pkg::cmd_t q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rp_reg, wp_reg;
    tbf_pkg::cmd_t c;
    logic push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_cmd   = q_reg[rp_reg];

    always_comb begin
        c.mode  = s_mode;
        c.addr  = s_mem_addr;
        c.wdata = s_mem_wdata;
        c.sx    = s_src_x;
        c.sy    = s_src_y;
        c.dx    = s_dst_x;
        c.dy    = s_dst_y;
        c.key   = s_color_key;
        c.fill  = s_fill_value[3:0];
        c.cols  = '0;
        c.rows  = '0;
        if (s_mode[1]) begin
            c.cols = tbf_pkg::clip(s_rect_width, s_dst_x, dst_width);
            c.rows = tbf_pkg::clip(s_rect_height, s_dst_y, dst_height);
        end
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) q_reg[wp_reg] <= c;
        if (!aresetn) begin
            cnt_reg <= '0;
            rp_reg  <= 1'b0;
            wp_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
        end
    end

    a_no_over: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !s_ready) else $error("queue overflow");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'd2) else $error("bad count");
    a_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> cnt_reg != 2'd0) else $error("pop empty");
endmodule

FILE: rtl/tbf_back.sv
// Back end: runs host accesses and pixel loops against the pixel memory.
// Depends on tbf_pkg.
module tbf_back (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  tbf_pkg::cmd_t            q_cmd,
    input  logic [tbf_pkg::AW-1:0]   src_base,
    input  logic [tbf_pkg::CW-1:0]   src_width,
    input  logic [tbf_pkg::AW-1:0]   dst_base,
    input  logic [tbf_pkg::CW-1:0]   dst_width,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [7:0]               m_read_data,
    output logic [tbf_pkg::CW-1:0]   m_drawn_width,
    output logic [tbf_pkg::CW-1:0]   m_drawn_height
);
    localparam int AW = tbf_pkg::AW;
    localparam int CW = tbf_pkg::CW;
    localparam logic [2:0] ST_IDLE = 3'd0, ST_HOST = 3'd1, ST_SRD = 3'd2,
                           ST_DRD = 3'd3, ST_DWR = 3'd4, ST_OUT = 3'd5,
                           ST_ADR = 3'd6;

    logic [7:0] mem [tbf_pkg::MEM_BYTES];
    logic [2:0] st_reg, st_next;
    tbf_pkg::cmd_t cmd_reg;
    logic [CW-1:0] i_reg, j_reg;
    logic [7:0] rdata_reg;
    logic [3:0] pix_reg;
    logic       skip_reg;
    logic [AW-1:0] sa_reg, da_reg, raddr;
    logic [CW:0]   qx, qy;
    logic [CW-1:0] px, py;
    logic [CW-1:0] sstr, dstr;
    logic [AW-6:0] sprod, dprod;
    logic [AW-1:0] soff, doff;
    logic m_valid_reg;
    logic mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0] mem_wd;

    // source is not clipped, so its coordinates carry one more bit
    assign qx = {1'b0, cmd_reg.sx} + {1'b0, i_reg};
    assign qy = {1'b0, cmd_reg.sy} + {1'b0, j_reg};
    assign px = cmd_reg.dx + i_reg;
    assign py = cmd_reg.dy + j_reg;
    assign sstr = tbf_pkg::stride(src_width);
    assign dstr = tbf_pkg::stride(dst_width);
    assign q_ready = (st_reg == ST_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;

    always_comb begin
        sprod = (AW-5)'(qy[CW:3]) * (AW-5)'(sstr);
        dprod = (AW-5)'(py[CW-1:3]) * (AW-5)'(dstr);
        soff = AW'({qx[CW:3], 5'd0}) + AW'({qy[2:0], 2'd0}) + AW'(qx[2:1]);
        doff = AW'({px[CW-1:3], 5'd0}) + AW'({py[2:0], 2'd0}) + AW'(px[2:1]);
    end

    always_comb begin
        raddr = sa_reg;
        if (st_reg == ST_IDLE) raddr = q_cmd.addr;
        else if (st_reg == ST_HOST) raddr = cmd_reg.addr;
        else if (st_reg == ST_DRD) raddr = da_reg;
        mem_we = 1'b0;
        mem_wa = da_reg;
        mem_wd = rdata_reg;
        if (st_reg == ST_IDLE && q_valid && q_ready && q_cmd.mode == tbf_pkg::MODE_WR) begin
            mem_we = 1'b1;
            mem_wa = q_cmd.addr;
            mem_wd = q_cmd.wdata;
        end else if (st_reg == ST_DWR && !skip_reg) begin
            mem_we = 1'b1;
            mem_wd = px[0] ? {pix_reg, rdata_reg[3:0]} : {rdata_reg[7:4], pix_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        rdata_reg <= mem[raddr];
    end

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: if (q_valid && q_ready) begin
                if (q_cmd.mode[1]) st_next = (q_cmd.cols == '0 || q_cmd.rows == '0)
                                               ? ST_OUT : ST_ADR;
                else st_next = ST_HOST;
            end
            ST_HOST: st_next = ST_OUT;
            ST_ADR:  st_next = (cmd_reg.mode == tbf_pkg::MODE_COPY) ? ST_SRD : ST_DRD;
            ST_SRD:  st_next = ST_DRD;
            ST_DRD:  st_next = ST_DWR;
            ST_DWR: begin
                if (i_reg == cmd_reg.cols - 1'b1 && j_reg == cmd_reg.rows - 1'b1)
                    st_next = ST_OUT;
                else st_next = ST_ADR;
            end
            ST_OUT:  st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (st_reg == ST_IDLE && q_valid && q_ready) begin
            cmd_reg <= q_cmd;
            i_reg <= '0;
            j_reg <= '0;
        end
        if (st_reg == ST_ADR) begin
            sa_reg <= src_base + soff + {sprod, 5'd0};
            da_reg <= dst_base + doff + {dprod, 5'd0};
            pix_reg <= cmd_reg.fill;
            skip_reg <= 1'b0;
        end
        if (st_reg == ST_DRD && cmd_reg.mode == tbf_pkg::MODE_COPY) begin
            pix_reg <= qx[0] ? rdata_reg[7:4] : rdata_reg[3:0];
            skip_reg <= (cmd_reg.key != tbf_pkg::KEY_OFF) &&
                        (cmd_reg.key == {4'd0, (qx[0] ? rdata_reg[7:4] : rdata_reg[3:0])});
        end
        if (st_reg == ST_DWR) begin
            if (i_reg == cmd_reg.cols - 1'b1) begin
                i_reg <= '0;
                j_reg <= j_reg + 1'b1;
            end else i_reg <= i_reg + 1'b1;
        end
        if (st_reg == ST_OUT) begin
            m_read_data    <= (cmd_reg.mode == tbf_pkg::MODE_RD) ? rdata_reg : 8'd0;
            m_drawn_width  <= cmd_reg.cols;
            m_drawn_height <= cmd_reg.rows;
        end
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (st_reg == ST_OUT) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg != ST_IDLE |-> !q_ready) else $error("accept while busy");
    a_out: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_OUT |=> m_valid) else $error("result lost");
endmodule

FILE: rtl/tiled_4bpp_blit_and_fill.sv
// Top level of the tiled 4bpp blit and fill engine.
// Depends on tbf_pkg, tbf_front, tbf_back.
//  channel | dir | handshake       | payload
//  s_      | in  | s_valid/s_ready | mode, addresses, rectangle, key, fill
//  m_      | out | m_valid/m_ready | read_data, drawn_width, drawn_height
//  cfg     | in  | cfg_we          | cfg_index, cfg_data
// Host byte access: each beat goes through the queue and then the back end.
// Copy a pixel: address, source read, dest read, write; fill has no source read.
// Sequencing is set by the single read port of the back end's memory.
// Reset is synchronous; memory contents are left as they are.
// A stalled result holds the back end; the front queue keeps taking two beats.
module tiled_4bpp_blit_and_fill (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [2:0]               cfg_index,
    input  logic [14:0]              cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_mode,
    input  logic [14:0]              s_mem_addr,
    input  logic [7:0]               s_mem_wdata,
    input  logic [9:0]               s_src_x,
    input  logic [9:0]               s_src_y,
    input  logic [9:0]               s_dst_x,
    input  logic [9:0]               s_dst_y,
    input  logic [9:0]               s_rect_width,
    input  logic [9:0]               s_rect_height,
    input  logic [7:0]               s_color_key,
    input  logic [7:0]               s_fill_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [7:0]               m_read_data,
    output logic [9:0]               m_drawn_width,
    output logic [9:0]               m_drawn_height
);
    logic [14:0] src_base_reg, dst_base_reg;
    logic [9:0]  src_width_reg, dst_width_reg, dst_height_reg;
    logic q_valid, q_ready;
    tbf_pkg::cmd_t q_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_base_reg <= '0;
            src_width_reg <= '0;
            dst_base_reg <= '0;
            dst_width_reg <= '0;
            dst_height_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                tbf_pkg::REG_SRC_BASE:   src_base_reg   <= cfg_data;
                tbf_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_data[9:0];
                tbf_pkg::REG_DST_BASE:   dst_base_reg   <= cfg_data;
                tbf_pkg::REG_DST_WIDTH:  dst_width_reg  <= cfg_data[9:0];
                tbf_pkg::REG_DST_HEIGHT: dst_height_reg <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    tbf_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_mode, .s_mem_addr, .s_mem_wdata,
        .s_src_x, .s_src_y, .s_dst_x, .s_dst_y, .s_rect_width, .s_rect_height,
        .s_color_key, .s_fill_value,
        .dst_width(dst_width_reg), .dst_height(dst_height_reg),
        .q_valid, .q_ready, .q_cmd
    );

    tbf_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_cmd,
        .src_base(src_base_reg), .src_width(src_width_reg),
        .dst_base(dst_base_reg), .dst_width(dst_width_reg),
        .m_valid, .m_ready, .m_read_data, .m_drawn_width, .m_drawn_height
    );
endmodule

FILE: test/tiled_4bpp_blit_and_fill_test.sv
// Testbench for tiled_4bpp_blit_and_fill: random host byte accesses, copies and fills.
// Uses tbf_pkg for mode and register codes; the scoreboard class predicts every beat.
`timescale 1ns / 100ps

module tiled_4bpp_blit_and_fill_test;
    // random host byte accesses stay inside a 512-byte window that wraps through address 0
    localparam int WIN_LO    = 32512;
    localparam int WIN_BYTES = 512;

    typedef struct {
        logic [1:0]  mode;
        logic [14:0] addr;
        logic [7:0]  wdata;
        logic [9:0]  sx, sy, dx, dy, rw, rh;
        logic [7:0]  key;
        logic [7:0]  fill;
    } blit_cmd_t;

    typedef struct {
        logic [7:0] rdata;
        logic [9:0] cols;
        logic [9:0] rows;
    } blit_res_t;

    class blit_scoreboard;
        bit [7:0]  pix_mem [tbf_pkg::MEM_BYTES];
        int        src_base, src_width, dst_base, dst_width, dst_height;
        blit_res_t expected_q[$];
        int        errors;

        function void set_reg(logic [2:0] idx, int val);
            case (idx)
                tbf_pkg::REG_SRC_BASE:   src_base   = val & 16'h7FFF;
                tbf_pkg::REG_SRC_WIDTH:  src_width  = val & 10'h3FF;
                tbf_pkg::REG_DST_BASE:   dst_base   = val & 16'h7FFF;
                tbf_pkg::REG_DST_WIDTH:  dst_width  = val & 10'h3FF;
                tbf_pkg::REG_DST_HEIGHT: dst_height = val & 10'h3FF;
                default: ;
            endcase
        endfunction

        function int clipped(int len, int start, int lim);
            if (start >= lim) return 0;
            return (len < lim - start) ? len : lim - start;
        endfunction

        function int tile_addr(int b, int w, int x, int y);
            int s;
            s = (w + (w & 7)) >> 3;
            return (b + ((x >> 1) & 3) + ((x >> 3) << 5) + (((y >> 3) * s) << 5)
                    + ((y & 7) << 2)) % tbf_pkg::MEM_BYTES;
        endfunction

        function void note(blit_cmd_t c);
            blit_res_t r;
            int i, j, da, sa, px, qx, v;
            r = '{8'd0, 10'd0, 10'd0};
            if (c.mode == tbf_pkg::MODE_WR) begin
                pix_mem[c.addr] = c.wdata;
            end else if (c.mode == tbf_pkg::MODE_RD) begin
                r.rdata = pix_mem[c.addr];
            end else begin
                r.cols = 10'(clipped(c.rw, c.dx, dst_width));
                r.rows = 10'(clipped(c.rh, c.dy, dst_height));
                for (j = 0; j < r.rows; j++) begin
                    for (i = 0; i < r.cols; i++) begin
                        px = c.dx + i;
                        da = tile_addr(dst_base, dst_width, px, c.dy + j);
                        if (c.mode == tbf_pkg::MODE_COPY) begin
                            qx = c.sx + i;
                            sa = tile_addr(src_base, src_width, qx, c.sy + j);
                            v = (pix_mem[sa] >> ((qx & 1) * 4)) & 4'hF;
                            if (c.key != tbf_pkg::KEY_OFF && v == c.key) continue;
                        end else begin
                            v = c.fill & 4'hF;
                        end
                        if (px & 1) pix_mem[da] = {v[3:0], pix_mem[da][3:0]};
                        else        pix_mem[da] = {pix_mem[da][7:4], v[3:0]};
                    end
                end
            end
            expected_q.push_back(r);
        endfunction

        function void check(blit_res_t got);
            blit_res_t e;
            if (expected_q.size() == 0) begin
                $error("unexpected result beat");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.rdata !== e.rdata) begin
                $error("read_data: expected %0h, got %0h", e.rdata, got.rdata);
                errors++;
            end
            if (got.cols !== e.cols) begin
                $error("drawn_width: expected %0d, got %0d", e.cols, got.cols);
                errors++;
            end
            if (got.rows !== e.rows) begin
                $error("drawn_height: expected %0d, got %0d", e.rows, got.rows);
                errors++;
            end
        endfunction
    endclass

    logic        aclk, aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [14:0] cfg_data;
    logic        s_valid, s_ready;
    logic [1:0]  s_mode;
    logic [14:0] s_mem_addr;
    logic [7:0]  s_mem_wdata;
    logic [9:0]  s_src_x, s_src_y, s_dst_x, s_dst_y, s_rect_width, s_rect_height;
    logic [7:0]  s_color_key, s_fill_value;
    logic        m_valid, m_ready;
    logic [7:0]  m_read_data;
    logic [9:0]  m_drawn_width, m_drawn_height;

    tiled_4bpp_blit_and_fill DUT (.*);

    blit_scoreboard sb = new();
    int idle_pct, stall_pct;
    int hold_req, hold_cnt;
    int cur_dw, cur_dh;

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #100_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(negedge aclk) begin
        if (hold_req) begin
            hold_cnt = 400;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note('{s_mode, s_mem_addr, s_mem_wdata, s_src_x, s_src_y, s_dst_x,
                          s_dst_y, s_rect_width, s_rect_height, s_color_key, s_fill_value});
            if (m_valid && m_ready)
                sb.check('{m_read_data, m_drawn_width, m_drawn_height});
        end
    end

    task automatic send(blit_cmd_t c);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_mode = c.mode; s_mem_addr = c.addr; s_mem_wdata = c.wdata;
        s_src_x = c.sx; s_src_y = c.sy; s_dst_x = c.dx; s_dst_y = c.dy;
        s_rect_width = c.rw; s_rect_height = c.rh;
        s_color_key = c.key; s_fill_value = c.fill;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain;
        s_valid = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, int val);
        cfg_we = 1'b1; cfg_index = idx; cfg_data = 15'(val);
        sb.set_reg(idx, val);
        if (idx == tbf_pkg::REG_DST_WIDTH) cur_dw = val;
        if (idx == tbf_pkg::REG_DST_HEIGHT) cur_dh = val;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic configure(int sb_, int sw, int db, int dw, int dh);
        drain();
        write_reg(tbf_pkg::REG_SRC_BASE, sb_);
        write_reg(tbf_pkg::REG_SRC_WIDTH, sw);
        write_reg(tbf_pkg::REG_DST_BASE, db);
        write_reg(tbf_pkg::REG_DST_WIDTH, dw);
        write_reg(tbf_pkg::REG_DST_HEIGHT, dh);
    endtask

    function automatic blit_cmd_t mk(int m, int a, int w, int sx, int sy, int dx, int dy,
                                     int rw, int rh, int key, int fill);
        blit_cmd_t c;
        c.mode  = 2'(m);
        c.addr  = 15'(a);
        c.wdata = 8'(w);
        c.sx    = 10'(sx);
        c.sy    = 10'(sy);
        c.dx    = 10'(dx);
        c.dy    = 10'(dy);
        c.rw    = 10'(rw);
        c.rh    = 10'(rh);
        c.key   = 8'(key);
        c.fill  = 8'(fill);
        return c;
    endfunction

    function automatic int win_addr(int off);
        return (WIN_LO + off) % tbf_pkg::MEM_BYTES;
    endfunction

    function automatic int rand_span();
        if ($urandom_range(0, 99) < 85) return $urandom_range(0, 12);
        return $urandom_range(0, 1023);
    endfunction

    function automatic int rand_start(int len, int lim);
        if (len > 16 && lim > 16) return lim - $urandom_range(0, 12);
        return $urandom_range(0, (lim + 4 > 1023) ? 1023 : lim + 4);
    endfunction

    function automatic blit_cmd_t rand_cmd();
        blit_cmd_t c;
        int p, k;
        p = $urandom_range(0, 99);
        c.mode  = (p < 25) ? tbf_pkg::MODE_WR : (p < 45) ? tbf_pkg::MODE_RD :
                  (p < 75) ? tbf_pkg::MODE_COPY : tbf_pkg::MODE_FILL;
        c.addr  = 15'(win_addr($urandom_range(0, WIN_BYTES - 1)));
        c.wdata = 8'($urandom_range(0, 255));
        c.sx    = 10'($urandom_range(0, 15));
        c.sy    = 10'($urandom_range(0, 15));
        c.rw    = 10'(rand_span());
        c.rh    = 10'(rand_span());
        c.dx    = 10'(rand_start(c.rw, cur_dw));
        c.dy    = 10'(rand_start(c.rh, cur_dh));
        k = $urandom_range(0, 99);
        c.key   = (k < 60) ? 8'($urandom_range(0, 15)) :
                  (k < 85) ? tbf_pkg::KEY_OFF : 8'($urandom_range(16, 254));
        c.fill  = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic int rand_dim();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) return $urandom_range(1, 16);
        if (p < 85) return 16;
        return $urandom_range(0, 16);
    endfunction

    initial begin
        int ph, n;
        hold_req = 0; hold_cnt = 0;
        idle_pct = 0; stall_pct = 0;
        cur_dw = 0; cur_dh = 0;
        aresetn = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        s_valid = 1'b0; m_ready = 1'b0;
        s_mode = tbf_pkg::MODE_WR; s_mem_addr = '0; s_mem_wdata = '0;
        s_src_x = '0; s_src_y = '0; s_dst_x = '0; s_dst_y = '0;
        s_rect_width = '0; s_rect_height = '0; s_color_key = '0; s_fill_value = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset config clips everything to nothing
        send(mk(tbf_pkg::MODE_COPY, 0, 0, 5, 5, 0, 0, 1023, 1023, tbf_pkg::KEY_OFF, 0));
        send(mk(tbf_pkg::MODE_FILL, 0, 0, 0, 0, 3, 3, 4, 4, 0, 8'hFF));

        // every byte of the window written once so later reads are defined
        for (n = 0; n < WIN_BYTES; n++)
            send(mk(tbf_pkg::MODE_WR, win_addr(n), $urandom_range(0, 255),
                    0, 0, 0, 0, 0, 0, 0, 0));

        // wide strides, source base at the top of memory so addresses wrap
        configure(32767, 1023, 0, 1023, 1023);
        send(mk(tbf_pkg::MODE_WR, 0, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0));
        send(mk(tbf_pkg::MODE_WR, 32767, 8'hFF, 0, 0, 0, 0, 0, 0, 0, 0));
        send(mk(tbf_pkg::MODE_RD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send(mk(tbf_pkg::MODE_RD, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send(mk(tbf_pkg::MODE_COPY, 0, 0, 0, 0, 0, 0, 16, 8, tbf_pkg::KEY_OFF, 0));
        send(mk(tbf_pkg::MODE_COPY, 0, 0, 0, 0, 0, 0, 16, 8, 5, 0));
        send(mk(tbf_pkg::MODE_COPY, 0, 0, 1, 2, 3, 1, 6, 4, 200, 0));
        send(mk(tbf_pkg::MODE_COPY, 0, 0, 0, 0, 1023, 0, 5, 5, 0, 0));
        send(mk(tbf_pkg::MODE_FILL, 0, 0, 0, 0, 0, 1023, 3, 3, 0, 8'hFF));
        send(mk(tbf_pkg::MODE_FILL, 0, 0, 0, 0, 1015, 0, 0, 1, 0, 8'hA7));
        send(mk(tbf_pkg::MODE_FILL, 0, 0, 0, 0, 0, 0, 8, 8, 0, 8'h50));
        send(mk(tbf_pkg::MODE_COPY, 0, 0, 0, 0, 0, 0, 4, 0, 0, 0));
        send(mk(tbf_pkg::MODE_RD, 100, 0, 0, 0, 0, 0, 0, 0, 0, 0));

        // zero source stride, source columns running past 1023
        configure(28672, 0, 100, 13, 9);
        send(mk(tbf_pkg::MODE_COPY, 0, 0, 1020, 0, 2, 3, 1023, 1023, 0, 0));
        send(mk(tbf_pkg::MODE_FILL, 0, 0, 0, 0, 13, 0, 4, 4, 0, 8'h0F));
        send(mk(tbf_pkg::MODE_FILL, 0, 0, 0, 0, 0, 9, 4, 4, 0, 8'h0F));
        send(mk(tbf_pkg::MODE_COPY, 0, 0, 1020, 9, 1, 1, 11, 7, 15, 0));

        for (ph = 0; ph < 12; ph++) begin
            configure(win_addr($urandom_range(0, 192)), $urandom_range(0, 16),
                      win_addr($urandom_range(0, 384)), rand_dim(), rand_dim());
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 83; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 83; end
                default: begin idle_pct = 8; stall_pct = 8; end
            endcase
            if (ph == 4) begin
                idle_pct = 0; stall_pct = 0;
                hold_req = 1;
            end
            for (n = 0; n < 58; n++) send(rand_cmd());
        end

        drain();
        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
